/* rtl/vrtp_pkg.sv */
// Shared types, codes and helpers for the vertex transform pipeline.
// No dependencies; used by vrtp_div_pipe and vertex_rotate_translate_project.
package vrtp_pkg;

    // Operation codes held in the op_mode register
    localparam logic [2:0] MODE_TRANSLATE = 3'd0;
    localparam logic [2:0] MODE_ROT_X     = 3'd1;
    localparam logic [2:0] MODE_ROT_Y     = 3'd2;
    localparam logic [2:0] MODE_ROT_Z     = 3'd3;
    localparam logic [2:0] MODE_PROJECT   = 3'd4;

    // Configuration register indexes
    localparam logic [3:0] REG_OP_MODE   = 4'd0;
    localparam logic [3:0] REG_COS       = 4'd1;
    localparam logic [3:0] REG_SIN       = 4'd2;
    localparam logic [3:0] REG_SHIFT_X   = 4'd3;
    localparam logic [3:0] REG_SHIFT_Y   = 4'd4;
    localparam logic [3:0] REG_SHIFT_Z   = 4'd5;
    localparam logic [3:0] REG_DISTANCE  = 4'd6;
    localparam logic [3:0] REG_SCREEN    = 4'd7;

    localparam int COORD_FRAC_BITS_DEF = 16;
    localparam int TRIG_FRAC_BITS      = 16;
    // Quotient bits kept by the divider; anything larger saturates anyway
    localparam int DIV_BITS            = 34;

    typedef struct packed {
        logic                flag;
        logic signed [31:0]  val;
    } sat_t;

    // Per-axis state of the projection divider
    typedef struct packed {
        logic                ov;
        logic                neg;
        logic [DIV_BITS-1:0] rem;
        logic [DIV_BITS-1:0] nlow;
        logic [DIV_BITS-1:0] quot;
    } axis_t;

    // One item as it travels through the divider stages
    typedef struct packed {
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic signed [31:0] qz;
        logic               bad;
        logic               last;
        logic               proj;
        logic               zero_den;
        logic [11:0]        w;
        logic [32:0]        ud;
        axis_t              ax;
        axis_t              ay;
    } div_item_t;

    // Clamp to the signed 32-bit range and flag a clamp
    function automatic sat_t sat32(logic signed [63:0] v);
        sat_t r;
        if (v > 64'sd2147483647)
        begin
            r.flag = 1'b1;
            r.val  = 32'sh7FFFFFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            r.flag = 1'b1;
            r.val  = 32'sh80000000;
        end
        else
        begin
            r.flag = 1'b0;
            r.val  = v[31:0];
        end
        return r;
    endfunction

    // Drop the trig fraction bits, rounding half away from zero
    function automatic logic signed [35:0] trig_round(logic signed [50:0] v);
        logic [50:0] mag;
        logic [50:0] m;
        mag = v[50] ? 51'(-v) : 51'(v);
        m   = (mag + 51'(1 << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS;
        return v[50] ? -signed'(m[35:0]) : signed'(m[35:0]);
    endfunction

endpackage

/* rtl/vrtp_div_pipe.sv */
// Pipelined restoring divider for both projection axes, one quotient bit a stage.
// Depends on vrtp_pkg for the item type and the quotient width.
module vrtp_div_pipe
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  vrtp_pkg::div_item_t in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output vrtp_pkg::div_item_t out_item
);

    localparam int N = vrtp_pkg::DIV_BITS;

    vrtp_pkg::div_item_t st_reg [N];
    logic [N-1:0]        v_reg;
    logic                en;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    function automatic vrtp_pkg::axis_t axis_step(vrtp_pkg::axis_t a, logic [32:0] ud);
        vrtp_pkg::axis_t r;
        logic [N:0]      r2;
        logic [N:0]      diff;
        r2      = {a.rem, a.nlow[N-1]};
        diff    = r2 - (N+1)'(ud);
        r       = a;
        r.rem   = diff[N] ? r2[N-1:0] : diff[N-1:0];
        r.nlow  = a.nlow << 1;
        r.quot  = {a.quot[N-2:0], ~diff[N]};
        return r;
    endfunction

    function automatic vrtp_pkg::div_item_t item_step(vrtp_pkg::div_item_t d);
        vrtp_pkg::div_item_t r;
        r    = d;
        r.ax = axis_step(d.ax, d.ud);
        r.ay = axis_step(d.ay, d.ud);
        return r;
    endfunction

    // Advance all stages together unless the last one is held
    assign en       = !v_reg[N-1] || !out_stall;
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= item_step(in_item);
            for (int i = 1; i < N; i++)
            begin
                st_reg[i] <= item_step(st_reg[i-1]);
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_item  = st_reg[N-1];

endmodule

/* rtl/vertex_rotate_translate_project.sv */
// Top level of the vertex transform pipeline: config registers, front stages, output stage.
// Depends on vrtp_pkg and vrtp_div_pipe.
//
// Takes one point per clock while in_stall is low and returns one result per point, in order.
// The path is a multiply stage, a stage that finishes rotation or translation and sets up
// the division, 34 divider stages (one quotient bit each, both projection axes side by side),
// and an output stage that adds the screen center and saturates.
// Every mode runs through the same stages. Stage 1, stage 2 and the output stage take
// a new item whenever they are empty, even under a downstream stall; the divider
// stages advance together, so gaps inside them stay until its last stage is freed.
// Configuration may be written only while no item is in flight.
module vertex_rotate_translate_project #(
    parameter int COORD_FRAC_BITS = vrtp_pkg::COORD_FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [3:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] px,
    input  logic signed [31:0] py,
    input  logic signed [31:0] pz,
    input  logic               last_point,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] qx,
    output logic signed [31:0] qy,
    output logic signed [31:0] qz,
    output logic signed [31:0] screen_x,
    output logic signed [31:0] screen_y,
    output logic               invalid,
    output logic               last_out
);

    localparam int QB = vrtp_pkg::DIV_BITS;
    localparam int NW = 45 + COORD_FRAC_BITS;
    localparam int HW = NW - QB;
    localparam int CW = (HW > 33) ? HW : 33;

    // Configuration registers
    logic [2:0]         mode_reg;
    logic signed [17:0] cos_reg;
    logic signed [17:0] sin_reg;
    logic signed [31:0] sx_reg;
    logic signed [31:0] sy_reg;
    logic signed [31:0] sz_reg;
    logic signed [31:0] dist_reg;
    logic [11:0]        size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= vrtp_pkg::MODE_TRANSLATE;
            cos_reg  <= 18'sd65536;
            sin_reg  <= '0;
            sx_reg   <= '0;
            sy_reg   <= '0;
            sz_reg   <= '0;
            dist_reg <= 32'sd327680;
            size_reg <= 12'd700;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                vrtp_pkg::REG_OP_MODE:  mode_reg <= cfg_data[2:0];
                vrtp_pkg::REG_COS:      cos_reg  <= cfg_data[17:0];
                vrtp_pkg::REG_SIN:      sin_reg  <= cfg_data[17:0];
                vrtp_pkg::REG_SHIFT_X:  sx_reg   <= cfg_data;
                vrtp_pkg::REG_SHIFT_Y:  sy_reg   <= cfg_data;
                vrtp_pkg::REG_SHIFT_Z:  sz_reg   <= cfg_data;
                vrtp_pkg::REG_DISTANCE: dist_reg <= cfg_data;
                vrtp_pkg::REG_SCREEN:   size_reg <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // Stage 1: products, offset sums and depth sum
    logic               v1_reg;
    logic signed [31:0] x1_reg, y1_reg, z1_reg;
    logic               last1_reg;
    logic [2:0]         mode1_reg;
    logic signed [49:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [44:0] nx_reg, ny_reg;
    logic signed [32:0] den_reg;
    logic signed [32:0] tx_reg, ty_reg, tz_reg;

    logic signed [31:0] u_sel, v_sel;
    logic               en1, en2, div_stall, en_out;

    // Pick the two rotated coordinates for the axis in use
    always_comb
    begin
        case (mode_reg)
            vrtp_pkg::MODE_ROT_X:
            begin
                u_sel = py;
                v_sel = pz;
            end
            vrtp_pkg::MODE_ROT_Y:
            begin
                u_sel = px;
                v_sel = pz;
            end
            default:
            begin
                u_sel = px;
                v_sel = py;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en1)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            x1_reg    <= px;
            y1_reg    <= py;
            z1_reg    <= pz;
            last1_reg <= last_point;
            mode1_reg <= mode_reg;
            p0_reg    <= cos_reg * u_sel;
            p1_reg    <= sin_reg * v_sel;
            p2_reg    <= sin_reg * u_sel;
            p3_reg    <= cos_reg * v_sel;
            nx_reg    <= px * signed'({1'b0, size_reg});
            ny_reg    <= py * signed'({1'b0, size_reg});
            den_reg   <= 33'(dist_reg) + 33'(pz);
            tx_reg    <= 33'(px) + 33'(sx_reg);
            ty_reg    <= 33'(py) + 33'(sy_reg);
            tz_reg    <= 33'(pz) + 33'(sz_reg);
        end
    end

    // Stage 2: finish rotation or translation, set up the division
    logic                v2_reg;
    vrtp_pkg::div_item_t d2_reg;
    vrtp_pkg::div_item_t d2_next;

    function automatic vrtp_pkg::axis_t axis_setup(logic signed [44:0] n,
                                                   logic signed [32:0] den,
                                                   logic [32:0] ud,
                                                   logic signed [31:0] c,
                                                   logic zd);
        vrtp_pkg::axis_t a;
        logic [43:0]     un;
        logic [NW-1:0]   num;
        logic [HW-1:0]   hi;
        un  = n[44] ? 44'(-n) : 44'(n);
        num = (NW'(un) << COORD_FRAC_BITS) + NW'(ud >> 1);
        hi  = num[NW-1:QB];
        a.rem  = QB'(hi);
        a.nlow = num[QB-1:0];
        a.quot = '0;
        a.ov   = zd ? (c != 0) : (CW'(hi) >= CW'(ud));
        a.neg  = zd ? c[31] : (n[44] != den[32]);
        return a;
    endfunction

    always_comb
    begin
        logic signed [50:0] r1, r2;
        logic [32:0]        ud;
        logic               zd;
        vrtp_pkg::sat_t     s0, s1, s2;

        ud = den_reg[32] ? 33'(-den_reg) : 33'(den_reg);
        zd = (den_reg == 0);

        if (mode1_reg == vrtp_pkg::MODE_ROT_Y)
        begin
            r1 = 51'(p0_reg) + 51'(p1_reg);
            r2 = 51'(p3_reg) - 51'(p2_reg);
        end
        else
        begin
            r1 = 51'(p0_reg) - 51'(p1_reg);
            r2 = 51'(p2_reg) + 51'(p3_reg);
        end

        d2_next          = '0;
        d2_next.qx       = x1_reg;
        d2_next.qy       = y1_reg;
        d2_next.qz       = z1_reg;
        d2_next.last     = last1_reg;
        d2_next.proj     = (mode1_reg == vrtp_pkg::MODE_PROJECT);
        d2_next.zero_den = zd;
        d2_next.w        = size_reg;
        d2_next.ud       = ud;
        d2_next.ax       = axis_setup(nx_reg, den_reg, ud, x1_reg, zd);
        d2_next.ay       = axis_setup(ny_reg, den_reg, ud, y1_reg, zd);

        s0 = vrtp_pkg::sat32(64'(vrtp_pkg::trig_round(r1)));
        s1 = vrtp_pkg::sat32(64'(vrtp_pkg::trig_round(r2)));
        s2 = vrtp_pkg::sat32(64'(tz_reg));

        case (mode1_reg)
            vrtp_pkg::MODE_TRANSLATE:
            begin
                s0 = vrtp_pkg::sat32(64'(tx_reg));
                s1 = vrtp_pkg::sat32(64'(ty_reg));
                d2_next.qx  = s0.val;
                d2_next.qy  = s1.val;
                d2_next.qz  = s2.val;
                d2_next.bad = s0.flag | s1.flag | s2.flag;
            end
            vrtp_pkg::MODE_ROT_X:
            begin
                d2_next.qy  = s0.val;
                d2_next.qz  = s1.val;
                d2_next.bad = s0.flag | s1.flag;
            end
            vrtp_pkg::MODE_ROT_Y:
            begin
                d2_next.qx  = s0.val;
                d2_next.qz  = s1.val;
                d2_next.bad = s0.flag | s1.flag;
            end
            vrtp_pkg::MODE_ROT_Z:
            begin
                d2_next.qx  = s0.val;
                d2_next.qy  = s1.val;
                d2_next.bad = s0.flag | s1.flag;
            end
            vrtp_pkg::MODE_PROJECT:
            begin
                d2_next.bad = zd;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            d2_reg <= d2_next;
        end
    end

    // Divider stages
    logic                dv_valid;
    vrtp_pkg::div_item_t dv_item;

    vrtp_div_pipe u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .in_stall  (div_stall),
        .in_item   (d2_reg),
        .out_valid (dv_valid),
        .out_stall (!en_out),
        .out_item  (dv_item)
    );

    // Stage enables: an empty stage always takes the next item
    assign en_out   = !out_valid || !out_stall;
    assign en2      = !v2_reg || !div_stall;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;

    // Output stage: add the screen center, saturate
    function automatic vrtp_pkg::sat_t axis_finish(vrtp_pkg::axis_t a, logic zd,
                                                   logic [11:0] w);
        vrtp_pkg::sat_t     r;
        logic [QB-1:0]      q;
        logic signed [36:0] m;
        logic signed [36:0] center;
        if (a.ov)
        begin
            r.flag = 1'b1;
            r.val  = a.neg ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        else
        begin
            q      = zd ? '0 : a.quot;
            m      = a.neg ? -signed'(37'(q)) : signed'(37'(q));
            center = signed'(37'(w) << (COORD_FRAC_BITS - 1));
            r      = vrtp_pkg::sat32(64'(center + m));
        end
        return r;
    endfunction

    logic signed [31:0] qx_reg, qy_reg, qz_reg, scx_reg, scy_reg;
    logic               bad_reg, last_reg, ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (en_out)
        begin
            ov_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        vrtp_pkg::sat_t fx, fy;
        fx = axis_finish(dv_item.ax, dv_item.zero_den, dv_item.w);
        fy = axis_finish(dv_item.ay, dv_item.zero_den, dv_item.w);
        if (en_out)
        begin
            qx_reg   <= dv_item.qx;
            qy_reg   <= dv_item.qy;
            qz_reg   <= dv_item.qz;
            scx_reg  <= dv_item.proj ? fx.val : '0;
            scy_reg  <= dv_item.proj ? fy.val : '0;
            bad_reg  <= dv_item.bad | (dv_item.proj & (fx.flag | fy.flag));
            last_reg <= dv_item.last;
        end
    end

    assign out_valid = ov_reg;
    assign qx        = qx_reg;
    assign qy        = qy_reg;
    assign qz        = qz_reg;
    assign screen_x  = scx_reg;
    assign screen_y  = scy_reg;
    assign invalid   = bad_reg;
    assign last_out  = last_reg;

endmodule

/* sim/tb.sv */
// Self-checking testbench for vertex_rotate_translate_project.
// Depends on rtl/vrtp_pkg.sv and the RTL top level; predicts every result in-line.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS = 16;
    localparam int RUN_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 45;
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam logic [3:0] REG_UNUSED = 4'd15;
    localparam logic signed [31:0] COORD_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] COORD_MIN = 32'sh80000000;
    localparam logic [31:0] Q16_ONE = 32'd65536;

    typedef struct packed {
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic signed [31:0] qz;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic               bad;
        logic               last;
    } vertex_out_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic [3:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [31:0] px = '0;
    logic signed [31:0] py = '0;
    logic signed [31:0] pz = '0;
    logic               last_point = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] qx;
    logic signed [31:0] qy;
    logic signed [31:0] qz;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic               invalid;
    logic               last_out;

    // Shadow copy of the configuration registers
    logic [2:0]         cur_mode = vrtp_pkg::MODE_TRANSLATE;
    logic signed [17:0] cur_cos = 18'sd65536;
    logic signed [17:0] cur_sin = '0;
    logic signed [31:0] cur_shift_x = '0;
    logic signed [31:0] cur_shift_y = '0;
    logic signed [31:0] cur_shift_z = '0;
    logic signed [31:0] cur_dist = 32'sd327680;
    logic [11:0]        cur_size = 12'd700;

    vertex_out_t pending_vertices[$];
    int  fail_count = 0;
    int  cycle_count = 0;
    bit  no_idle = 1'b0;
    bit  pressure_go = 1'b0;
    bit  pressure_used = 1'b0;
    int  stall_left = 0;

    vertex_rotate_translate_project i_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Clamp to 32-bit signed range, flag a clamp
    function automatic logic signed [31:0] clamp32(longint v, inout bit bad);
        if (v > 64'sd2147483647)
        begin
            bad = 1'b1;
            return COORD_MAX;
        end
        if (v < -64'sd2147483648)
        begin
            bad = 1'b1;
            return COORD_MIN;
        end
        return v[31:0];
    endfunction

    // Drop 16 trig fraction bits, round half away from zero
    function automatic longint drop_trig_frac(longint v);
        longint unsigned mag;
        mag = v < 0 ? -v : v;
        mag = (mag + 64'd32768) >> 16;
        return v < 0 ? -longint'(mag) : longint'(mag);
    endfunction

    // W/2 + c*W/den, unsaturated, den nonzero
    function automatic longint project_axis(longint c, longint den, longint w);
        longint n, center;
        longint unsigned un, ud, q, r, m;
        bit neg;
        n = c * w;
        neg = (n < 0) != (den < 0);
        un = n < 0 ? -n : n;
        ud = den < 0 ? -den : den;
        q = un / ud;
        r = un % ud;
        center = w << (FRAC_BITS - 1);
        if (q >= 64'h1_0000_0000)
            m = 64'h100_0000_0000;
        else
            m = (q << FRAC_BITS) + (((r << FRAC_BITS) + ud / 2) / ud);
        if (n == 0)
            m = 0;
        return center + (neg ? -longint'(m) : longint'(m));
    endfunction

    function automatic vertex_out_t transform_vertex(logic signed [31:0] x, logic signed [31:0] y,
                                                     logic signed [31:0] z, logic lst);
        vertex_out_t o;
        bit bad;
        longint c, s, xl, yl, zl, den, w, center;
        bad = 1'b0;
        c = cur_cos;
        s = cur_sin;
        xl = x;
        yl = y;
        zl = z;
        o.qx = x;
        o.qy = y;
        o.qz = z;
        o.sx = '0;
        o.sy = '0;
        case (cur_mode)
            vrtp_pkg::MODE_TRANSLATE:
            begin
                o.qx = clamp32(xl + longint'(cur_shift_x), bad);
                o.qy = clamp32(yl + longint'(cur_shift_y), bad);
                o.qz = clamp32(zl + longint'(cur_shift_z), bad);
            end
            vrtp_pkg::MODE_ROT_X:
            begin
                o.qy = clamp32(drop_trig_frac(c * yl - s * zl), bad);
                o.qz = clamp32(drop_trig_frac(s * yl + c * zl), bad);
            end
            vrtp_pkg::MODE_ROT_Y:
            begin
                o.qx = clamp32(drop_trig_frac(c * xl + s * zl), bad);
                o.qz = clamp32(drop_trig_frac(c * zl - s * xl), bad);
            end
            vrtp_pkg::MODE_ROT_Z:
            begin
                o.qx = clamp32(drop_trig_frac(c * xl - s * yl), bad);
                o.qy = clamp32(drop_trig_frac(s * xl + c * yl), bad);
            end
            vrtp_pkg::MODE_PROJECT:
            begin
                den = longint'(cur_dist) + zl;
                w = cur_size;
                if (den == 0)
                begin
                    center = w << (FRAC_BITS - 1);
                    bad = 1'b1;
                    o.sx = xl > 0 ? COORD_MAX : (xl < 0 ? COORD_MIN : clamp32(center, bad));
                    o.sy = yl > 0 ? COORD_MAX : (yl < 0 ? COORD_MIN : clamp32(center, bad));
                end
                else
                begin
                    o.sx = clamp32(project_axis(xl, den, w), bad);
                    o.sy = clamp32(project_axis(yl, den, w), bad);
                end
            end
            default:
            begin
            end
        endcase
        o.bad = bad;
        o.last = lst;
        return o;
    endfunction

    // Gap before the next item: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: return COORD_MAX;
                    1: return COORD_MIN;
                    2: return 32'sd0;
                    3: return 32'sd1;
                    default: return -32'sd1;
                endcase
            end
            1, 2, 3, 4: return $urandom;
            default: return $signed($urandom_range(0, 32'h3FFFFF)) - 32'sh200000;
        endcase
    endfunction

    task automatic write_reg(logic [3:0] idx, logic [31:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            vrtp_pkg::REG_OP_MODE:  cur_mode = data[2:0];
            vrtp_pkg::REG_COS:      cur_cos = data[17:0];
            vrtp_pkg::REG_SIN:      cur_sin = data[17:0];
            vrtp_pkg::REG_SHIFT_X:  cur_shift_x = data;
            vrtp_pkg::REG_SHIFT_Y:  cur_shift_y = data;
            vrtp_pkg::REG_SHIFT_Z:  cur_shift_z = data;
            vrtp_pkg::REG_DISTANCE: cur_dist = data;
            vrtp_pkg::REG_SCREEN:   cur_size = data[11:0];
            default:
            begin
            end
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Offer one item, hold it until accepted, then predict its result
    task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z, logic lst);
        int gap;
        in_valid <= 1'b1;
        px <= x;
        py <= y;
        pz <= z;
        last_point <= lst;
        do
            @(posedge clk);
        while (in_stall);
        pending_vertices.push_back(transform_vertex(x, y, z, lst));
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random(int count);
        logic signed [31:0] z;
        repeat (count)
        begin
            z = rand_coord();
            if (cur_mode == vrtp_pkg::MODE_PROJECT && $urandom_range(0, 9) == 0)
                z = -cur_dist;
            send_vertex(rand_coord(), rand_coord(), z, 1'($urandom_range(0, 1)));
        end
    endtask

    // Drain the pipeline before touching configuration
    task automatic wait_idle();
        in_valid <= 1'b0;
        wait (pending_vertices.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        send_vertex(COORD_MAX, COORD_MIN, 32'sd0, 1'b1);
        send_vertex(32'sd65536, -32'sd65536, 32'sd12345, 1'b0);
    endtask

    task automatic test_translate();
        wait_idle();
        write_reg(vrtp_pkg::REG_SHIFT_X, COORD_MAX);
        write_reg(vrtp_pkg::REG_SHIFT_Y, COORD_MIN);
        write_reg(vrtp_pkg::REG_SHIFT_Z, 32'hFFFF0000);
        send_vertex(32'sd1, -32'sd1, COORD_MIN, 1'b0);
        send_vertex(COORD_MIN, COORD_MAX, COORD_MAX, 1'b1);
        send_vertex(-32'sd1, 32'sd0, 32'sd0, 1'b0);
    endtask

    task automatic test_rotate();
        wait_idle();
        write_reg(vrtp_pkg::REG_COS, Q16_ONE);
        write_reg(vrtp_pkg::REG_SIN, Q16_ONE);
        for (int m = vrtp_pkg::MODE_ROT_X; m <= vrtp_pkg::MODE_ROT_Z; m++)
        begin
            wait_idle();
            write_reg(vrtp_pkg::REG_OP_MODE, m);
            send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
            send_vertex(COORD_MIN, 32'sd98304, -32'sd32768, 1'b1);
        end
        wait_idle();
        write_reg(vrtp_pkg::REG_COS, -Q16_ONE);
        write_reg(vrtp_pkg::REG_SIN, -Q16_ONE);
        send_vertex(COORD_MIN, COORD_MIN, COORD_MAX, 1'b0);
        send_vertex(32'sd1, -32'sd1, 32'sd3, 1'b1);
    endtask

    task automatic test_project();
        wait_idle();
        write_reg(vrtp_pkg::REG_OP_MODE, vrtp_pkg::MODE_PROJECT);
        write_reg(vrtp_pkg::REG_SCREEN, 32'd4095);
        write_reg(vrtp_pkg::REG_DISTANCE, 32'd0);
        // zero depth sum: each sign of each coordinate
        send_vertex(32'sd5, -32'sd5, 32'sd0, 1'b0);
        send_vertex(32'sd0, 32'sd0, 32'sd0, 1'b1);
        send_vertex(-32'sd7, 32'sd9, 32'sd0, 1'b0);
        // tiny depth gives a huge quotient
        send_vertex(COORD_MAX, COORD_MIN, 32'sd1, 1'b0);
        wait_idle();
        write_reg(vrtp_pkg::REG_DISTANCE, COORD_MIN);
        write_reg(vrtp_pkg::REG_SCREEN, 32'd0);
        send_vertex(32'sd65536, -32'sd65536, COORD_MIN, 1'b1);
        send_vertex(COORD_MAX, 32'sd3, -32'sd1, 1'b0);
        wait_idle();
        write_reg(vrtp_pkg::REG_SCREEN, 32'd1);
        write_reg(vrtp_pkg::REG_DISTANCE, 32'sd327680);
        send_vertex(32'sd65536, -32'sd98304, 32'sd65536, 1'b0);
    endtask

    task automatic test_spare_modes();
        wait_idle();
        write_reg(REG_UNUSED, 32'hFFFFFFFF);
        for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++)
        begin
            wait_idle();
            write_reg(vrtp_pkg::REG_OP_MODE, m);
            send_vertex(rand_coord(), rand_coord(), rand_coord(), 1'b1);
        end
    endtask

    // Receiver holds off for a long stretch while items keep coming
    task automatic test_back_pressure();
        wait_idle();
        write_reg(vrtp_pkg::REG_OP_MODE, vrtp_pkg::MODE_ROT_Y);
        no_idle = 1'b1;
        pressure_go = 1'b1;
        send_random(100);
        pressure_go = 1'b0;
        no_idle = 1'b0;
    endtask

    task automatic test_random_phases();
        logic [31:0] data;
        for (int phase = 0; phase < 9; phase++)
        begin
            wait_idle();
            no_idle = (phase % 3 == 0);
            write_reg(vrtp_pkg::REG_OP_MODE, phase < 5 ? phase : $urandom_range(0, 7));
            for (int idx = vrtp_pkg::REG_COS; idx <= vrtp_pkg::REG_SCREEN; idx++)
            begin
                data = $urandom;
                if ($urandom_range(0, 3) == 0)
                    data = $urandom_range(0, 1) ? 32'hFFFF0000 : Q16_ONE;
                else if (idx == vrtp_pkg::REG_DISTANCE || idx == vrtp_pkg::REG_SCREEN)
                    data = $urandom_range(0, 1) ? $urandom_range(1, 32'h7FFFFF) : data;
                write_reg(4'(idx), data);
            end
            send_random(50);
        end
        no_idle = 1'b0;
    endtask

    // Receiver stall: random bursts, one long hold on request
    always @(posedge clk)
    begin
        int r;
        if (pressure_go && !pressure_used)
        begin
            pressure_used <= 1'b1;
            stall_left <= 200;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (no_idle)
            out_stall <= 1'b0;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 20)
            begin
                out_stall <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end
            else if (r < 22)
            begin
                out_stall <= 1'b1;
                stall_left <= $urandom_range(10, 40);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        vertex_out_t exp_v;
        vertex_out_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{qx, qy, qz, screen_x, screen_y, invalid, last_out};
            if (pending_vertices.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, got);
                fail_count++;
            end
            else
            begin
                exp_v = pending_vertices.pop_front();
                if (got.qx !== exp_v.qx)
                    $display("%0t: qx expected %0d got %0d", $time, exp_v.qx, got.qx);
                if (got.qy !== exp_v.qy)
                    $display("%0t: qy expected %0d got %0d", $time, exp_v.qy, got.qy);
                if (got.qz !== exp_v.qz)
                    $display("%0t: qz expected %0d got %0d", $time, exp_v.qz, got.qz);
                if (got.sx !== exp_v.sx)
                    $display("%0t: screen_x expected %0d got %0d", $time, exp_v.sx, got.sx);
                if (got.sy !== exp_v.sy)
                    $display("%0t: screen_y expected %0d got %0d", $time, exp_v.sy, got.sy);
                if (got.bad !== exp_v.bad)
                    $display("%0t: invalid expected %0b got %0b", $time, exp_v.bad, got.bad);
                if (got.last !== exp_v.last)
                    $display("%0t: last_out expected %0b got %0b", $time, exp_v.last, got.last);
                if (got !== exp_v)
                    fail_count++;
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_translate();
        test_rotate();
        test_project();
        test_spare_modes();
        test_back_pressure();
        test_random_phases();
        wait_idle();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
rtl/vrtp_pkg.sv
rtl/vrtp_div_pipe.sv
rtl/vertex_rotate_translate_project.sv
sim/tb.sv
